### sv/sdrq_pkg.sv
// shared types and codes for the stream descriptor ring queue
package sdrq_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_DEPTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_STILL       = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  CFG_HDR_CODE    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] DEPTH_CFG_RESET = 7'd64;

    // request codes
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    // request beat
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] in_start_addr;
        logic [31:0] in_end_addr;
        logic [31:0] in_size;
        logic [3:0]  in_pic_type;
    } req_t;

    // response beat
    typedef struct packed {
        logic        done_ok;
        logic [31:0] out_start_addr;
        logic [31:0] out_end_addr;
        logic [31:0] out_size;
        logic [3:0]  out_pic_type;
        logic [5:0]  entry_count;
        logic [31:0] merged_size;
    } rsp_t;

    // one ring slot
    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [31:0] size;
        logic [3:0]  frame_code;
    } desc_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_POP_DATA = 2'd1,
        ST_WALK     = 2'd2
    } state_t;

    // where a response is built from
    typedef enum logic [1:0] {
        RES_FLAG  = 2'd0,
        RES_POP   = 2'd1,
        RES_QUERY = 2'd2
    } res_src_t;

    // controller to datapath
    typedef struct packed {
        logic     push_we;
        logic     pop_adv;
        logic     walk_rd;
        logic     query_start;
        logic     walk_step;
        logic     res_load;
        res_src_t res_src;
        logic     res_ok;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic res_free;
        logic walk_adv;
    } dp_status_t;

endpackage

### sv/sdrq_ctrl.sv
// sequencing of push, pop and query walk for the descriptor ring
module sdrq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic [1:0]             req_action,
    input  sdrq_pkg::dp_status_t   sts,
    output logic                   ready,
    output sdrq_pkg::ctrl_cmd_t    cmd
);
    import sdrq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        ready           = 1'b0;
        accept          = 1'b0;
        cmd             = '0;
        cmd.res_src     = RES_FLAG;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready  = sts.res_free;
                accept = req_valid && sts.res_free;
                if (accept)
                begin
                    unique case (req_action)
                        ACT_PUSH:
                        begin
                            cmd.push_we  = !sts.full;
                            cmd.res_load = 1'b1;
                            cmd.res_ok   = !sts.full;
                        end
                        ACT_POP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.res_load = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_adv = 1'b1;
                                state_next  = ST_POP_DATA;
                            end
                        end
                        ACT_QUERY:
                        begin
                            cmd.query_start = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_ok   = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            // unknown code: refused, nothing changes
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_DATA:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_POP;
                cmd.res_ok   = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (sts.walk_adv)
                begin
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = RES_QUERY;
                    cmd.res_ok   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/sdrq_datapath.sv
// ring storage, indices, walk sum and response stages
module sdrq_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdrq_pkg::req_t                      req,
    input  logic                                cfg_we,
    input  logic [sdrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdrq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  sdrq_pkg::ctrl_cmd_t                 cmd,
    output sdrq_pkg::dp_status_t                sts,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output sdrq_pkg::rsp_t                      rsp
);
    import sdrq_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int DEP_W = $clog2(RING_DEPTH + 1);
    localparam int CNT_W = (DEP_W > 6) ? DEP_W : 6;

    // configuration
    logic [CFG_DATA_W-1:0] depth_cfg_reg;
    logic                  still_reg;
    logic [3:0]            hdr_code_reg;

    // ring state
    desc_t             ring_mem [RING_DEPTH];
    desc_t             rdata_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  node_reg;
    logic [31:0]       sum_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // response stages
    logic              res_valid_reg;
    rsp_t              res_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [DEP_W-1:0]  depth_eff;
    logic [IDX_W-1:0]  wr_adv;
    logic [IDX_W-1:0]  rd_adv;
    logic [IDX_W-1:0]  node_adv;
    logic [IDX_W-1:0]  raddr;
    logic [CNT_W-1:0]  cnt_now;
    logic [32:0]       sum_wide;
    logic [31:0]       new_sum;
    logic              walk_last;
    logic              walk_hdr;
    logic              res_move;
    rsp_t              res_new;

    function automatic logic [IDX_W-1:0] ring_adv(
        input logic [IDX_W-1:0] idx,
        input logic [DEP_W-1:0] dep
    );
        logic [DEP_W-1:0] n;
        n = DEP_W'(idx) + DEP_W'(1);
        return (n >= dep) ? '0 : n[IDX_W-1:0];
    endfunction

    // effective depth, clamped to at least 2 and at most the ring size
    always_comb
    begin
        if (depth_cfg_reg < CFG_DATA_W'(2))
        begin
            depth_eff = DEP_W'(2);
        end
        else if (32'(depth_cfg_reg) > RING_DEPTH)
        begin
            depth_eff = DEP_W'(RING_DEPTH);
        end
        else
        begin
            depth_eff = DEP_W'(depth_cfg_reg);
        end
    end

    // index arithmetic and occupancy
    assign wr_adv   = ring_adv(wr_idx_reg, depth_eff);
    assign rd_adv   = ring_adv(rd_idx_reg, depth_eff);
    assign node_adv = ring_adv(node_reg, depth_eff);
    assign raddr    = cmd.walk_rd ? node_adv : rd_idx_reg;

    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            cnt_now = CNT_W'(wr_idx_reg) - CNT_W'(rd_idx_reg);
        end
        else
        begin
            cnt_now = CNT_W'(wr_idx_reg) + CNT_W'(depth_eff) - CNT_W'(rd_idx_reg);
        end
    end

    // saturating walk sum and stop test
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, rdata_reg.size};
    assign new_sum   = sum_wide[32] ? '1 : sum_wide[31:0];
    assign walk_last = (node_adv == wr_idx_reg);
    assign walk_hdr  = still_reg && (rdata_reg.frame_code == hdr_code_reg);

    assign sts.full     = (wr_adv == rd_idx_reg);
    assign sts.empty    = (wr_idx_reg == rd_idx_reg);
    assign sts.walk_adv = !walk_last && ((new_sum == 32'd0) || walk_hdr);
    assign res_move     = res_valid_reg && (!out_valid_reg || !rsp_stall);
    assign sts.res_free = !res_valid_reg || res_move;

    // response build
    always_comb
    begin
        res_new         = '0;
        res_new.done_ok = cmd.res_ok;
        case (cmd.res_src)
            RES_POP:
            begin
                res_new.out_start_addr = rdata_reg.start_addr;
                res_new.out_end_addr   = rdata_reg.end_addr;
                res_new.out_size       = rdata_reg.size;
                res_new.out_pic_type   = rdata_reg.frame_code;
            end
            RES_QUERY:
            begin
                // walk that ends on a header reports no count and no merged size
                if (!walk_hdr)
                begin
                    res_new.entry_count = cnt_reg[5:0];
                    res_new.merged_size = new_sum;
                end
            end
            default:
            begin
                res_new.done_ok = cmd.res_ok;
            end
        endcase
    end

    // ring memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push_we)
        begin
            ring_mem[wr_idx_reg] <= '{start_addr: req.in_start_addr,
                                      end_addr:   req.in_end_addr,
                                      size:       req.in_size,
                                      frame_code: req.in_pic_type};
        end
        rdata_reg <= ring_mem[raddr];
    end

    // configuration and indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_cfg_reg <= DEPTH_CFG_RESET;
            still_reg     <= 1'b0;
            hdr_code_reg  <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            // a new ring size empties the queue
            if (cfg_we && (cfg_index == CFG_DEPTH))
            begin
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
            end
            else
            begin
                if (cmd.push_we)
                begin
                    wr_idx_reg <= wr_adv;
                end
                if (cmd.pop_adv)
                begin
                    rd_idx_reg <= rd_adv;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEPTH:
                    begin
                        depth_cfg_reg <= cfg_data;
                    end
                    CFG_STILL:
                    begin
                        still_reg <= cfg_data[0];
                    end
                    CFG_HDR_CODE:
                    begin
                        hdr_code_reg <= cfg_data[3:0];
                    end
                    default:
                    begin
                        still_reg <= still_reg;
                    end
                endcase
            end
        end
    end

    // walk position, sum and count
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            node_reg <= rd_idx_reg;
            sum_reg  <= '0;
            cnt_reg  <= cnt_now;
        end
        else if (cmd.walk_step)
        begin
            node_reg <= node_adv;
            sum_reg  <= new_sum;
        end
    end

    // response slot and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end
            if (res_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_new;
        end
        if (res_move)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### sv/stream_descriptor_ring_queue.sv
// top level of the stream descriptor ring queue
//
//  channel  signals                          beat
//  -------  -------------------------------  -----------------------------------
//  request  req_valid, req_stall, req        push, pop or query of descriptors
//  response rsp_valid, rsp_stall, rsp        one status and payload per request
//  config   cfg_we, cfg_index, cfg_data      register write, no handshake
//
// push and refused requests load their response straight from the request; a pop
// loads it after the registered ring memory read, and a query after a merge walk
// that steps over entries, one memory read per step.
// a response slot and an output register sit between request and response, so
// a new request is taken while the previous response is stalled downstream.
// reset clears indices and control; the ring memory is not cleared.
module stream_descriptor_ring_queue #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  sdrq_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output sdrq_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [sdrq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdrq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sdrq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic       ready;

    // controller
    sdrq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .sts        (sts),
        .ready      (ready),
        .cmd        (cmd)
    );

    // datapath
    sdrq_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign req_stall = !ready;

    // checks
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_we |-> !sts.full)
        else $error("push written into a full ring");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_adv |-> !sts.empty)
        else $error("read index advanced on an empty ring");

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> sts.res_free)
        else $error("response overwrote a pending response");

    a_walk_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.query_start && !sts.empty) |=> cmd.walk_rd)
        else $error("query did not start its walk");

endmodule
